FILE: design/lazy_range_add_minmax_tree_core_assert.svh
// Assertion macros shared by the checker.
`ifndef LAZY_RANGE_ADD_MINMAX_TREE_CORE_ASSERT_SVH
`define LAZY_RANGE_ADD_MINMAX_TREE_CORE_ASSERT_SVH

// Same-cycle implication.
`define LRT_ASSERT_IMPL(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define LRT_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/lrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lrt_pkg;

    localparam int unsigned LEAVES_DEF = 1024;

    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned LEFT_W  = 10;
    localparam int unsigned RIGHT_W = 11;
    localparam int unsigned DATA_W  = 64;

    localparam int unsigned IN_W  = 88;
    localparam int unsigned OUT_W = 72;

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_BUILD = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd3;

    localparam logic MODE_MIN = 1'b0;

    localparam logic [DATA_W-1:0] MIN_IDENT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] MAX_IDENT = 64'h8000_0000_0000_0000;

    // Signed min or max of two node values.
    function automatic logic [DATA_W-1:0] combine(
        input logic [DATA_W-1:0] a,
        input logic [DATA_W-1:0] b,
        input logic              mode
    );
        logic lt;
        lt = $signed(a) < $signed(b);
        if (mode == MODE_MIN)
        begin
            return lt ? a : b;
        end
        return lt ? b : a;
    endfunction

endpackage
`default_nettype wire

FILE: design/lazy_range_add_minmax_tree_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Lazy segment tree with range add and range min/max query.
// Input channel s_*: one operation per transfer (load leaf, build, range add,
// range query). Output channel m_*: one result per range query only.
// cfg_we/cfg_wdata write the mode bit (0 min, 1 max); the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Node values and pending adds live in two single-port-read synchronous
// memories; an add step reads an entry in S_A_RD and writes it back in S_A_WR.
// Load writes the leaf from the idle state; build recomputes every internal node
// from the last down to the root; range add applies the value to the covering
// nodes, then rebuilds the ancestors of the first and last leaf; range query
// pushes pending adds down two paths, then scans the covering nodes; an empty
// query goes straight to the result. Only one operation is in flight.
// After reset the block clears both memories with s_tready low. A query result
// is held in an output register; if the receiver stalls, the next query waits
// in S_DONE with s_tready low until the earlier result is taken.
module lazy_range_add_minmax_tree_core #(
    parameter int unsigned LEAVES = lrt_pkg::LEAVES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // func[1:0], left[11:2], right[22:12], value[86:23], zero[87]
    input  logic [lrt_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // query_value[63:0], empty_range[64], zero[71:65]
    output logic [lrt_pkg::OUT_W-1:0]  m_tdata
);
    import lrt_pkg::*;

    localparam int unsigned NAW = $clog2(2 * LEAVES);
    localparam int unsigned PAW = $clog2(LEAVES);
    localparam int unsigned XW  = NAW + 1;
    localparam int unsigned H   = $clog2(LEAVES + 1);
    localparam int unsigned SW  = $clog2(H + 1);

    typedef enum logic [22:0] {
        S_CLR   = 23'd1 << 0,
        S_IDLE  = 23'd1 << 1,
        S_BD    = 23'd1 << 2,
        S_AS_L  = 23'd1 << 3,
        S_AS_R  = 23'd1 << 4,
        S_AS_SH = 23'd1 << 5,
        S_AU    = 23'd1 << 6,
        S_QP    = 23'd1 << 7,
        S_QS_L  = 23'd1 << 8,
        S_QS_LW = 23'd1 << 9,
        S_QS_R  = 23'd1 << 10,
        S_QS_RW = 23'd1 << 11,
        S_QS_SH = 23'd1 << 12,
        S_DONE  = 23'd1 << 13,
        S_A_RD  = 23'd1 << 14,
        S_A_WR  = 23'd1 << 15,
        S_R_RD0 = 23'd1 << 16,
        S_R_RD1 = 23'd1 << 17,
        S_R_WR  = 23'd1 << 18,
        S_P_RD  = 23'd1 << 19,
        S_P_CHK = 23'd1 << 20,
        S_P_2   = 23'd1 << 21,
        S_P_3   = 23'd1 << 22
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;

    logic [NAW-1:0]    p_reg, p_next, up_reg, up_next, r0m1_reg, r0m1_next;
    logic [NAW-1:0]    qt_reg, qt_next, clr_reg, clr_next;
    logic [XW-1:0]     l_reg, l_next, r_reg, r_next;
    logic [SW-1:0]     s_reg, s_next;
    logic              sel_reg, sel_next;
    logic [PAW-1:0]    pi_reg, pi_next;
    logic [DATA_W-1:0] addv_reg, addv_next, a_reg, a_next, pd_reg, pd_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              empty_reg, empty_next;
    logic              mode_reg;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] qv_reg, qv_next;
    logic              qe_reg, qe_next;

    logic [DATA_W-1:0] node_mem [2*LEAVES];
    logic [DATA_W-1:0] pend_mem [LEAVES];
    logic [DATA_W-1:0] node_rdata, pend_rdata;
    logic              node_we, pend_we;
    logic [NAW-1:0]    node_waddr, node_raddr;
    logic [PAW-1:0]    pend_waddr, pend_raddr;
    logic [DATA_W-1:0] node_wdata, pend_wdata;

    logic [FUNC_W-1:0]  in_func;
    logic [LEFT_W-1:0]  in_left;
    logic [RIGHT_W-1:0] in_right;
    logic [DATA_W-1:0]  in_value;
    int unsigned        left_i, rc_i;
    logic [NAW-1:0]     qp_idx;

    assign in_func  = s_tdata[1:0];
    assign in_left  = s_tdata[11:2];
    assign in_right = s_tdata[22:12];
    assign in_value = s_tdata[86:23];

    assign left_i = 32'(in_left);
    assign rc_i   = (32'(in_right) > LEAVES) ? LEAVES : 32'(in_right);
    assign qp_idx = qt_reg >> s_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, qe_reg, qv_reg};

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rdata <= node_mem[node_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pend_mem[pend_waddr] <= pend_wdata;
        end
        pend_rdata <= pend_mem[pend_raddr];
    end

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        p_next       = p_reg;
        up_next      = up_reg;
        r0m1_next    = r0m1_reg;
        qt_next      = qt_reg;
        clr_next     = clr_reg;
        l_next       = l_reg;
        r_next       = r_reg;
        s_next       = s_reg;
        sel_next     = sel_reg;
        pi_next      = pi_reg;
        addv_next    = addv_reg;
        a_next       = a_reg;
        pd_next      = pd_reg;
        acc_next     = acc_reg;
        empty_next   = empty_reg;
        qv_next      = qv_reg;
        qe_next      = qe_reg;
        m_valid_next = m_valid_reg && !m_tready;
        node_we      = 1'b0;
        node_waddr   = p_reg;
        node_wdata   = '0;
        node_raddr   = p_reg;
        pend_we      = 1'b0;
        pend_waddr   = p_reg[PAW-1:0];
        pend_wdata   = '0;
        pend_raddr   = p_reg[PAW-1:0];

        case (state_reg)
            S_CLR:
            begin
                node_we    = 1'b1;
                node_waddr = clr_reg;
                pend_we    = (clr_reg < NAW'(LEAVES));
                pend_waddr = clr_reg[PAW-1:0];
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == NAW'(2 * LEAVES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (in_func)
                        FUNC_LOAD:
                        begin
                            if (left_i < LEAVES)
                            begin
                                node_we    = 1'b1;
                                node_waddr = NAW'(left_i + LEAVES);
                                node_wdata = in_value;
                            end
                        end
                        FUNC_BUILD:
                        begin
                            up_next    = NAW'(LEAVES - 1);
                            state_next = S_BD;
                        end
                        FUNC_ADD:
                        begin
                            if (left_i < rc_i)
                            begin
                                l_next     = XW'(left_i + LEAVES);
                                r_next     = XW'(rc_i + LEAVES);
                                up_next    = NAW'(left_i + LEAVES);
                                r0m1_next  = NAW'(rc_i + LEAVES - 1);
                                sel_next   = 1'b0;
                                addv_next  = in_value;
                                state_next = S_AS_L;
                            end
                        end
                        default:
                        begin
                            if (left_i < rc_i)
                            begin
                                l_next     = XW'(left_i + LEAVES);
                                r_next     = XW'(rc_i + LEAVES);
                                qt_next    = NAW'(left_i + LEAVES);
                                s_next     = SW'(H);
                                sel_next   = 1'b0;
                                acc_next   = (mode_reg == MODE_MIN) ? MIN_IDENT : MAX_IDENT;
                                empty_next = 1'b0;
                                state_next = S_QP;
                            end
                            else
                            begin
                                acc_next   = '0;
                                empty_next = 1'b1;
                                state_next = S_DONE;
                            end
                        end
                    endcase
                end
            end
            S_BD:
            begin
                if (up_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    p_next     = up_reg;
                    up_next    = up_reg - 1'b1;
                    ret_next   = S_BD;
                    state_next = S_R_RD0;
                end
            end
            S_AS_L:
            begin
                if (l_reg >= r_reg)
                begin
                    state_next = S_AU;
                end
                else if (l_reg[0])
                begin
                    p_next     = l_reg[NAW-1:0];
                    l_next     = l_reg + 1'b1;
                    ret_next   = S_AS_R;
                    state_next = S_A_RD;
                end
                else
                begin
                    state_next = S_AS_R;
                end
            end
            S_AS_R:
            begin
                if (r_reg[0])
                begin
                    p_next     = NAW'(r_reg - 1'b1);
                    r_next     = r_reg - 1'b1;
                    ret_next   = S_AS_SH;
                    state_next = S_A_RD;
                end
                else
                begin
                    state_next = S_AS_SH;
                end
            end
            S_AS_SH:
            begin
                l_next     = l_reg >> 1;
                r_next     = r_reg >> 1;
                state_next = S_AS_L;
            end
            S_AU:
            begin
                // Rebuild ancestors of the first leaf, then of the last leaf.
                if (up_reg > NAW'(1))
                begin
                    p_next     = up_reg >> 1;
                    up_next    = up_reg >> 1;
                    ret_next   = S_AU;
                    state_next = S_R_RD0;
                end
                else if (!sel_reg)
                begin
                    sel_next = 1'b1;
                    up_next  = r0m1_reg;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_QP:
            begin
                if (s_reg == '0)
                begin
                    if (!sel_reg)
                    begin
                        sel_next = 1'b1;
                        qt_next  = NAW'(r_reg - 1'b1);
                        s_next   = SW'(H);
                    end
                    else
                    begin
                        state_next = S_QS_L;
                    end
                end
                else
                begin
                    s_next = s_reg - 1'b1;
                    if (qp_idx != '0 && qp_idx < NAW'(LEAVES))
                    begin
                        pi_next    = qp_idx[PAW-1:0];
                        state_next = S_P_RD;
                    end
                end
            end
            S_QS_L:
            begin
                if (l_reg >= r_reg)
                begin
                    state_next = S_DONE;
                end
                else if (l_reg[0])
                begin
                    node_raddr = l_reg[NAW-1:0];
                    l_next     = l_reg + 1'b1;
                    state_next = S_QS_LW;
                end
                else
                begin
                    state_next = S_QS_R;
                end
            end
            S_QS_LW:
            begin
                acc_next   = combine(acc_reg, node_rdata, mode_reg);
                state_next = S_QS_R;
            end
            S_QS_R:
            begin
                if (r_reg[0])
                begin
                    node_raddr = NAW'(r_reg - 1'b1);
                    r_next     = r_reg - 1'b1;
                    state_next = S_QS_RW;
                end
                else
                begin
                    state_next = S_QS_SH;
                end
            end
            S_QS_RW:
            begin
                acc_next   = combine(acc_reg, node_rdata, mode_reg);
                state_next = S_QS_SH;
            end
            S_QS_SH:
            begin
                l_next     = l_reg >> 1;
                r_next     = r_reg >> 1;
                state_next = S_QS_L;
            end
            S_DONE:
            begin
                // Hold until the previous result has been transferred.
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    qv_next      = acc_reg;
                    qe_next      = empty_reg;
                    state_next   = S_IDLE;
                end
            end
            S_A_RD:
            begin
                state_next = S_A_WR;
            end
            S_A_WR:
            begin
                node_we    = 1'b1;
                node_wdata = node_rdata + addv_reg;
                pend_we    = (p_reg < NAW'(LEAVES));
                pend_wdata = pend_rdata + addv_reg;
                state_next = ret_reg;
            end
            S_R_RD0:
            begin
                node_raddr = {p_reg[NAW-2:0], 1'b0};
                state_next = S_R_RD1;
            end
            S_R_RD1:
            begin
                a_next     = node_rdata;
                pd_next    = pend_rdata;
                node_raddr = {p_reg[NAW-2:0], 1'b1};
                state_next = S_R_WR;
            end
            S_R_WR:
            begin
                node_we    = 1'b1;
                node_wdata = combine(a_reg, node_rdata, mode_reg) + pd_reg;
                state_next = ret_reg;
            end
            S_P_RD:
            begin
                pend_raddr = pi_reg;
                state_next = S_P_CHK;
            end
            S_P_CHK:
            begin
                if (pend_rdata == '0)
                begin
                    state_next = S_QP;
                end
                else
                begin
                    addv_next  = pend_rdata;
                    p_next     = {pi_reg, 1'b0};
                    ret_next   = S_P_2;
                    state_next = S_A_RD;
                end
            end
            S_P_2:
            begin
                p_next     = {pi_reg, 1'b1};
                ret_next   = S_P_3;
                state_next = S_A_RD;
            end
            S_P_3:
            begin
                pend_we    = 1'b1;
                pend_waddr = pi_reg;
                state_next = S_QP;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            ret_reg     <= S_IDLE;
            clr_reg     <= '0;
            mode_reg    <= MODE_MIN;
            m_valid_reg <= 1'b0;
            sel_reg     <= 1'b0;
            s_reg       <= '0;
            up_reg      <= '0;
            l_reg       <= '0;
            r_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            sel_reg     <= sel_next;
            s_reg       <= s_next;
            up_reg      <= up_next;
            l_reg       <= l_next;
            r_reg       <= r_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        r0m1_reg  <= r0m1_next;
        qt_reg    <= qt_next;
        pi_reg    <= pi_next;
        addv_reg  <= addv_next;
        a_reg     <= a_next;
        pd_reg    <= pd_next;
        acc_reg   <= acc_next;
        empty_reg <= empty_next;
        qv_reg    <= qv_next;
        qe_reg    <= qe_next;
    end

endmodule
`default_nettype wire

FILE: design/lrt_core_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "lazy_range_add_minmax_tree_core_assert.svh"
module lrt_core_chk (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      s_tvalid,
    input wire logic                      s_tready,
    input wire logic [lrt_pkg::IN_W-1:0]  s_tdata,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [lrt_pkg::OUT_W-1:0] m_tdata
);
    import lrt_pkg::*;

    `LRT_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `LRT_ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    // Build and query always leave the block busy in the cycle after they are accepted.
    `LRT_ASSERT_NEXT(a_busy_after_long_op, clk, rst_n,
        s_tvalid && s_tready && (s_tdata[1:0] == FUNC_BUILD || s_tdata[1:0] == FUNC_QUERY),
        !s_tready)
    `LRT_ASSERT_IMPL(a_empty_zero, clk, rst_n, m_tvalid && m_tdata[64],
        m_tdata[63:0] == 64'd0 && m_tdata[71:65] == 7'd0)

endmodule

bind lazy_range_add_minmax_tree_core lrt_core_chk u_lrt_core_chk (.*);
`default_nettype wire

FILE: tb/sv/lazy_range_add_minmax_tree_core_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module lazy_range_add_minmax_tree_core_tb;
    import lrt_pkg::*;

    localparam int unsigned NLEAF = 1024;
    localparam int unsigned HEIGHT = 11;
    localparam int unsigned IDLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 400;

    typedef struct packed {
        logic [DATA_W-1:0] qval;
        logic              empty;
    } tree_result_t;

    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [LEFT_W-1:0]  left;
        logic [RIGHT_W-1:0] right;
        logic [DATA_W-1:0]  value;
        logic               known;
        logic [DATA_W-1:0]  known_val;
        logic               known_empty;
    } op_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [0:0]           cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    logic [OUT_W-1:0]     m_tdata;

    lazy_range_add_minmax_tree_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    // Local copy of the tree state
    logic [DATA_W-1:0] tree_node[2*NLEAF];
    logic [DATA_W-1:0] tree_lazy[NLEAF];
    logic              tree_mode;

    tree_result_t      pending_results[$];
    logic              known_flag[$];
    tree_result_t      known_result[$];
    int unsigned       fail_count;
    int unsigned       idle_cycles;
    int unsigned       send_idle_pct;
    int unsigned       recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    function automatic logic [DATA_W-1:0] pick(input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b);
        logic lt;
        lt = $signed(a) < $signed(b);
        if (tree_mode == MODE_MIN)
        begin
            return lt ? a : b;
        end
        return lt ? b : a;
    endfunction

    function automatic void node_add(input int unsigned p, input logic [DATA_W-1:0] v);
        tree_node[p] = tree_node[p] + v;
        if (p < NLEAF)
        begin
            tree_lazy[p] = tree_lazy[p] + v;
        end
    endfunction

    function automatic void fix_path(input int unsigned leaf);
        int unsigned p;
        p = leaf;
        while (p > 1)
        begin
            p = p >> 1;
            tree_node[p] = pick(tree_node[2*p], tree_node[2*p+1]) + tree_lazy[p];
        end
    endfunction

    function automatic void push_path(input int unsigned leaf);
        int unsigned i;
        for (int s = HEIGHT; s > 0; s--)
        begin
            i = leaf >> s;
            if (i > 0 && i < NLEAF && tree_lazy[i] != '0)
            begin
                node_add(2*i, tree_lazy[i]);
                node_add(2*i+1, tree_lazy[i]);
                tree_lazy[i] = '0;
            end
        end
    endfunction

    // Apply one operation to the local tree; return 1 with a result for a query.
    function automatic bit tree_apply(input logic [FUNC_W-1:0] func,
                                      input logic [LEFT_W-1:0] left,
                                      input logic [RIGHT_W-1:0] right,
                                      input logic [DATA_W-1:0] value,
                                      output tree_result_t res);
        int unsigned l;
        int unsigned r;
        int unsigned rc;
        int unsigned l0;
        int unsigned r0;
        logic [DATA_W-1:0] acc;
        res = '0;
        if (func == FUNC_LOAD)
        begin
            tree_node[NLEAF + left] = value;
            return 0;
        end
        if (func == FUNC_BUILD)
        begin
            for (int i = NLEAF - 1; i > 0; i--)
            begin
                tree_node[i] = pick(tree_node[2*i], tree_node[2*i+1]) + tree_lazy[i];
            end
            return 0;
        end
        rc = (right > NLEAF) ? NLEAF : right;
        if (func == FUNC_ADD)
        begin
            if (left >= rc)
            begin
                return 0;
            end
            l = left + NLEAF;
            r = rc + NLEAF;
            l0 = l;
            r0 = r;
            while (l < r)
            begin
                if (l[0])
                begin
                    node_add(l, value);
                    l++;
                end
                if (r[0])
                begin
                    r--;
                    node_add(r, value);
                end
                l = l >> 1;
                r = r >> 1;
            end
            fix_path(l0);
            fix_path(r0 - 1);
            return 0;
        end
        if (left >= rc)
        begin
            res.qval = '0;
            res.empty = 1'b1;
            return 1;
        end
        l = left + NLEAF;
        r = rc + NLEAF;
        push_path(l);
        push_path(r - 1);
        acc = (tree_mode == MODE_MIN) ? MIN_IDENT : MAX_IDENT;
        while (l < r)
        begin
            if (l[0])
            begin
                acc = pick(acc, tree_node[l]);
                l++;
            end
            if (r[0])
            begin
                r--;
                acc = pick(acc, tree_node[r]);
            end
            l = l >> 1;
            r = r >> 1;
        end
        res.qval = acc;
        res.empty = 1'b0;
        return 1;
    endfunction

    // Drive one operation and record what it should produce.
    task automatic send_op(input op_row_t row);
        tree_result_t res;
        bit gap;
        gap = (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct);
        if (gap)
        begin
            s_tvalid <= 1'b0;
            while (gap)
            begin
                @(posedge clk);
                gap = ($urandom_range(99) < send_idle_pct);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, row.value, row.right, row.left, row.func};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        if (tree_apply(row.func, row.left, row.right, row.value, res))
        begin
            pending_results.push_back(res);
            known_flag.push_back(row.known);
            known_result.push_back('{qval: row.known_val, empty: row.known_empty});
        end
    endtask

    task automatic set_mode(input logic m);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        // a build or add can still run after the last query result
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        tree_mode = m;
    endtask

    function automatic op_row_t mk(input logic [FUNC_W-1:0] f, input int unsigned l,
                                   input int unsigned r, input logic [DATA_W-1:0] v);
        op_row_t row;
        row.func = f;
        row.left = LEFT_W'(l);
        row.right = RIGHT_W'(r);
        row.value = v;
        row.known = 1'b0;
        row.known_val = '0;
        row.known_empty = 1'b0;
        return row;
    endfunction

    function automatic op_row_t mk_known(input logic [FUNC_W-1:0] f, input int unsigned l,
                                         input int unsigned r, input logic [DATA_W-1:0] v,
                                         input logic [DATA_W-1:0] q, input logic e);
        op_row_t row;
        row = mk(f, l, r, v);
        row.known = 1'b1;
        row.known_val = q;
        row.known_empty = e;
        return row;
    endfunction

    function automatic logic [DATA_W-1:0] rand_value();
        logic [DATA_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(5))
            0: v = MIN_IDENT;
            1: v = MAX_IDENT;
            2: v = {{54{v[63]}}, v[9:0]};
            default: ;
        endcase
        return v;
    endfunction

    function automatic op_row_t rand_op(input int unsigned span);
        int unsigned l;
        int unsigned r;
        int unsigned k;
        logic [FUNC_W-1:0] f;
        k = $urandom_range(99);
        if (k < 15)
        begin
            f = FUNC_LOAD;
        end
        else if (k < 18)
        begin
            f = FUNC_BUILD;
        end
        else if (k < 55)
        begin
            f = FUNC_ADD;
        end
        else
        begin
            f = FUNC_QUERY;
        end
        l = $urandom_range(NLEAF - 1);
        case ($urandom_range(9))
            0: r = $urandom_range(2047);
            1: r = $urandom_range(l);
            2: r = NLEAF;
            default: r = l + 1 + $urandom_range(span);
        endcase
        if (r > 2047)
        begin
            r = 2047;
        end
        return mk(f, l, r, rand_value());
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        tree_result_t got;
        tree_result_t want;
        logic kf;
        tree_result_t kr;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.qval = m_tdata[63:0];
            got.empty = m_tdata[64];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result qval=%h empty=%b", $time, got.qval, got.empty);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                kf = known_flag.pop_front();
                kr = known_result.pop_front();
                if (kf && kr != want)
                begin
                    $display("%0t: table row disagrees, table %h/%b predicted %h/%b",
                             $time, kr.qval, kr.empty, want.qval, want.empty);
                    fail_count++;
                end
                if (got.qval !== want.qval)
                begin
                    $display("%0t: query_value expected %h actual %h",
                             $time, want.qval, got.qval);
                    fail_count++;
                end
                if (got.empty !== want.empty)
                begin
                    $display("%0t: empty_range expected %b actual %b",
                             $time, want.empty, got.empty);
                    fail_count++;
                end
            end
        end
    end

    // Receiver stall
    always @(posedge clk)
    begin
        if (recv_stall_pct == 0)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        op_row_t table_rows[$];
        int unsigned phase_pct[4][2];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        tree_mode = MODE_MIN;
        for (int i = 0; i < 2 * NLEAF; i++)
        begin
            tree_node[i] = '0;
        end
        for (int i = 0; i < NLEAF; i++)
        begin
            tree_lazy[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // After reset everything reads zero; extremes and empty ranges are obvious.
        table_rows.push_back(mk_known(FUNC_QUERY, 0, 1024, '0, '0, 1'b0));
        table_rows.push_back(mk_known(FUNC_QUERY, 1023, 2047, '0, '0, 1'b0));
        table_rows.push_back(mk_known(FUNC_QUERY, 5, 5, '0, '0, 1'b1));
        table_rows.push_back(mk_known(FUNC_QUERY, 1023, 1023, '0, '0, 1'b1));
        table_rows.push_back(mk_known(FUNC_QUERY, 900, 3, '0, '0, 1'b1));
        table_rows.push_back(mk(FUNC_ADD, 10, 5, 64'd99));
        table_rows.push_back(mk(FUNC_LOAD, 0, 0, MAX_IDENT));
        table_rows.push_back(mk(FUNC_LOAD, 1023, 2047, MIN_IDENT));
        table_rows.push_back(mk(FUNC_LOAD, 512, 0, 64'hFFFF_FFFF_FFFF_FFFF));
        table_rows.push_back(mk(FUNC_QUERY, 0, 1024, '0));
        table_rows.push_back(mk(FUNC_BUILD, 0, 0, '0));
        table_rows.push_back(mk_known(FUNC_QUERY, 0, 1024, '0, MAX_IDENT, 1'b0));
        table_rows.push_back(mk_known(FUNC_QUERY, 1023, 1024, '0, MIN_IDENT, 1'b0));
        table_rows.push_back(mk(FUNC_ADD, 0, 2047, 64'd1));
        table_rows.push_back(mk(FUNC_QUERY, 0, 1, '0));
        table_rows.push_back(mk(FUNC_QUERY, 1023, 1024, '0));
        table_rows.push_back(mk(FUNC_ADD, 3, 700, 64'h8000_0000_0000_0001));
        table_rows.push_back(mk(FUNC_QUERY, 2, 701, '0));
        table_rows.push_back(mk(FUNC_BUILD, 0, 0, '0));
        table_rows.push_back(mk(FUNC_QUERY, 0, 1024, '0));
        foreach (table_rows[i])
        begin
            send_op(table_rows[i]);
        end

        // Mode change keeps old internal nodes until rebuilt.
        set_mode(1'b1);
        send_op(mk(FUNC_QUERY, 0, 1024, '0));
        send_op(mk(FUNC_ADD, 100, 101, 64'd5));
        send_op(mk(FUNC_QUERY, 0, 1024, '0));
        send_op(mk(FUNC_BUILD, 0, 0, '0));
        send_op(mk(FUNC_QUERY, 0, 1024, '0));

        phase_pct = '{'{0, 0}, '{59, 0}, '{0, 59}, '{27, 27}};
        for (int ph = 0; ph < 8; ph++)
        begin
            send_idle_pct = phase_pct[ph % 4][0];
            recv_stall_pct = phase_pct[ph % 4][1];
            if (ph % 2 == 1)
            begin
                set_mode(1'($urandom_range(1)));
            end
            // A fresh load/build sequence every few phases
            if (ph % 3 == 0)
            begin
                for (int i = 0; i < 24; i++)
                begin
                    send_op(mk(FUNC_LOAD, $urandom_range(NLEAF - 1), 0, rand_value()));
                end
                send_op(mk(FUNC_BUILD, 0, 0, '0));
            end
            for (int i = 0; i < 215; i++)
            begin
                send_op(rand_op((i % 4 == 0) ? NLEAF : 16));
            end
        end
        set_mode(1'b0);
        for (int i = 0; i < 40; i++)
        begin
            send_op(rand_op(64));
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
+incdir+design
design/lrt_pkg.sv
design/lazy_range_add_minmax_tree_core.sv
design/lrt_core_chk.sv
tb/sv/lazy_range_add_minmax_tree_core_tb.sv
